[sv/dna_pkg.sv]
// ----------------------------------------------------------------------------
// dna_pkg
// Shared widths, codes and item types for the dual number ALU.
// ----------------------------------------------------------------------------
package dna_pkg;

  // Number format
  localparam int DW  = 32;          // data width
  localparam int FB  = 16;          // fraction bits
  localparam int DDW = 2 * DW;      // full product width
  localparam int RW  = 2 * DW + 1;  // widest signed intermediate
  localparam int NW  = DDW + FB;    // dividend magnitude width
  localparam int QB  = DW + 1;      // quotient bits, top bit flags overflow
  localparam int QIW = $clog2(QB);  // quotient bit index width
  localparam int CW  = DDW + QB;    // trial compare width

  localparam logic signed [RW-1:0] SAT_MAX = signed'(RW'({1'b0, {(DW-1){1'b1}}}));
  localparam logic signed [RW-1:0] SAT_MIN = -SAT_MAX - 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DIV = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic signed [DW-1:0] a_value;
    logic signed [DW-1:0] a_deriv;
    logic signed [DW-1:0] b_value;
    logic signed [DW-1:0] b_deriv;
  } in_item_t;

  typedef struct packed {
    logic signed [DW-1:0] res_value;
    logic signed [DW-1:0] res_deriv;
    status_t              status;
  } out_item_t;

  // One sign-magnitude division in flight
  typedef struct packed {
    logic           neg;
    logic [NW-1:0]  rem;
    logic [DDW-1:0] den;
    logic [QB-1:0]  quo;
  } div_lane_t;

  // Control and non-divide results that ride along the divider
  typedef struct packed {
    logic                 is_div;
    logic                 bad;
    logic signed [RW-1:0] rv;
    logic signed [RW-1:0] rd;
  } side_t;

endpackage

[sv/dual_number_alu_core.sv]
// ----------------------------------------------------------------------------
// dual_number_alu_core
// Dual number ALU: add, subtract, product rule and quotient rule on
// signed Q16.16 values and derivatives, with saturation and status.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_item  (req_type, operands)
//   out_    | output    | out_valid/out_stall| out_item (results, status)
//
// One item per cycle while out_stall does not hold the result; two front
// stages (products, then sums and divider setup), 33 divider stages at one
// quotient bit each, one output stage. The divider makes up most of the latency.
// Reset clears all valid bits; payload registers are not reset.
// A stalled result freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module dual_number_alu_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dna_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dna_pkg::out_item_t  out_item
);
  import dna_pkg::*;

  logic      en;
  logic      f_vld, d_vld;
  div_lane_t f_val, f_der, d_val, d_der;
  side_t     f_side, d_side;

  // Advance everything unless the result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  dna_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_item  (in_item),
    .out_vld  (f_vld),
    .val_lane (f_val),
    .der_lane (f_der),
    .side     (f_side)
  );

  dna_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (f_vld),
    .val_in   (f_val),
    .der_in   (f_der),
    .side_in  (f_side),
    .out_vld  (d_vld),
    .val_out  (d_val),
    .der_out  (d_der),
    .side_out (d_side)
  );

  dna_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (d_vld),
    .val_lane  (d_val),
    .der_lane  (d_der),
    .side      (d_side),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[sv/dna_front.sv]
// ----------------------------------------------------------------------------
// dna_front
// Two register stages: operand products, then add/sub/mul results and
// divider setup.
// ----------------------------------------------------------------------------
module dna_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  dna_pkg::in_item_t   in_item,
  output logic                out_vld,
  output dna_pkg::div_lane_t  val_lane,
  output dna_pkg::div_lane_t  der_lane,
  output dna_pkg::side_t      side
);
  import dna_pkg::*;

  logic                  v1_r;
  op_t                   op1_r;
  logic signed [DW-1:0]  av1_r, ad1_r, bv1_r, bd1_r;
  logic signed [DDW-1:0] pab1_r, pad1_r, pda1_r, pbb1_r;

  logic                  v2_r;
  div_lane_t             val2_r, der2_r, val2_nxt, der2_nxt;
  side_t                 side2_r, side2_nxt;

  logic signed [RW-1:0]  dsum, dnum;
  logic [DW-1:0]         av_mag;
  logic [DDW-1:0]        num_mag;

  // Stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  // Stage 1: form the four products
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= op_t'(in_item.req_type);
      av1_r  <= in_item.a_value;
      ad1_r  <= in_item.a_deriv;
      bv1_r  <= in_item.b_value;
      bd1_r  <= in_item.b_deriv;
      pab1_r <= DDW'(in_item.a_value) * DDW'(in_item.b_value);
      pad1_r <= DDW'(in_item.a_value) * DDW'(in_item.b_deriv);
      pda1_r <= DDW'(in_item.a_deriv) * DDW'(in_item.b_value);
      pbb1_r <= DDW'(in_item.b_value) * DDW'(in_item.b_value);
    end
  end

  // Stage 2: componentwise results and divider operands
  always_comb begin
    dsum    = RW'(pad1_r) + RW'(pda1_r);
    dnum    = RW'(pda1_r) - RW'(pad1_r);
    av_mag  = av1_r[DW-1] ? DW'(-av1_r) : DW'(av1_r);
    num_mag = dnum[RW-1] ? DDW'(-dnum) : DDW'(dnum);

    val2_nxt.neg = av1_r[DW-1];
    val2_nxt.rem = NW'({av_mag, {FB{1'b0}}});
    val2_nxt.den = DDW'($unsigned(bv1_r));
    val2_nxt.quo = '0;

    der2_nxt.neg = dnum[RW-1];
    der2_nxt.rem = {num_mag, {FB{1'b0}}};
    der2_nxt.den = $unsigned(pbb1_r);
    der2_nxt.quo = '0;

    side2_nxt.is_div = (op1_r == OP_DIV);
    side2_nxt.bad    = (op1_r == OP_DIV) && (bv1_r[DW-1] || (bv1_r == '0));
    case (op1_r)
      OP_ADD: begin
        side2_nxt.rv = RW'(av1_r) + RW'(bv1_r);
        side2_nxt.rd = RW'(ad1_r) + RW'(bd1_r);
      end
      OP_SUB: begin
        side2_nxt.rv = RW'(av1_r) - RW'(bv1_r);
        side2_nxt.rd = RW'(ad1_r) - RW'(bd1_r);
      end
      OP_MUL: begin
        side2_nxt.rv = RW'(pab1_r >>> FB);
        side2_nxt.rd = dsum >>> FB;
      end
      default: begin
        side2_nxt.rv = '0;
        side2_nxt.rd = '0;
      end
    endcase
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val2_r  <= val2_nxt;
      der2_r  <= der2_nxt;
      side2_r <= side2_nxt;
    end
  end

  assign out_vld  = v2_r;
  assign val_lane = val2_r;
  assign der_lane = der2_r;
  assign side     = side2_r;

endmodule

[sv/dna_divider.sv]
// ----------------------------------------------------------------------------
// dna_divider
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// The first stage resolves the overflow bit above the result range.
// ----------------------------------------------------------------------------
module dna_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  dna_pkg::div_lane_t  val_in,
  input  dna_pkg::div_lane_t  der_in,
  input  dna_pkg::side_t      side_in,
  output logic                out_vld,
  output dna_pkg::div_lane_t  val_out,
  output dna_pkg::div_lane_t  der_out,
  output dna_pkg::side_t      side_out
);
  import dna_pkg::*;

  logic      vld_r  [QB];
  div_lane_t val_r  [QB];
  div_lane_t der_r  [QB];
  side_t     side_r [QB];

  // One restoring step at quotient bit pos
  function automatic div_lane_t div_step(input div_lane_t l, input logic [QIW-1:0] pos);
    logic [CW-1:0] part;
    logic [CW-1:0] trial;
    div_lane_t     r;
    part  = CW'(l.den) << pos;
    trial = CW'(l.rem);
    r     = l;
    if (trial >= part) begin
      r.rem      = NW'(trial - part);
      r.quo[pos] = 1'b1;
    end
    return r;
  endfunction

  for (genvar k = 0; k < QB; k++) begin : g_stg
    logic      vin;
    div_lane_t vi, di;
    side_t     si;

    if (k == 0) begin : g_head
      assign vin = in_vld;
      assign vi  = val_in;
      assign di  = der_in;
      assign si  = side_in;
    end else begin : g_body
      assign vin = vld_r[k-1];
      assign vi  = val_r[k-1];
      assign di  = der_r[k-1];
      assign si  = side_r[k-1];
    end

    // Advance the valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vin;
      end
    end

    // Resolve one quotient bit per lane
    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k]  <= div_step(vi, QIW'(QB - 1 - k));
        der_r[k]  <= div_step(di, QIW'(QB - 1 - k));
        side_r[k] <= si;
      end
    end
  end

  assign out_vld  = vld_r[QB-1];
  assign val_out  = val_r[QB-1];
  assign der_out  = der_r[QB-1];
  assign side_out = side_r[QB-1];

  a_val_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QB-1] && !side_r[QB-1].bad && side_r[QB-1].is_div && !val_r[QB-1].quo[QB-1]
    |-> CW'(val_r[QB-1].rem) < CW'(val_r[QB-1].den))
    else $error("value remainder not below divisor");

  a_der_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QB-1] && !side_r[QB-1].bad && side_r[QB-1].is_div && !der_r[QB-1].quo[QB-1]
    |-> CW'(der_r[QB-1].rem) < CW'(der_r[QB-1].den))
    else $error("derivative remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && vld_r[0] |=> vld_r[0] && $stable(val_r[0]))
    else $error("divider stage lost an item under stall");

endmodule

[sv/dna_back.sv]
// ----------------------------------------------------------------------------
// dna_back
// Output stage: signs the quotients, saturates and sets the status.
// ----------------------------------------------------------------------------
module dna_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  dna_pkg::div_lane_t  val_lane,
  input  dna_pkg::div_lane_t  der_lane,
  input  dna_pkg::side_t      side,
  output logic                out_valid,
  output dna_pkg::out_item_t  out_item
);
  import dna_pkg::*;

  localparam logic signed [DW-1:0] OUT_MAX = SAT_MAX[DW-1:0];
  localparam logic signed [DW-1:0] OUT_MIN = SAT_MIN[DW-1:0];

  logic                 out_valid_r;
  out_item_t            out_item_r, out_item_nxt;
  logic signed [RW-1:0] rv, rd;
  logic                 hi_v, lo_v, hi_d, lo_d;

  function automatic logic signed [RW-1:0] lane_sgn(input div_lane_t l);
    logic signed [RW-1:0] m;
    m = signed'(RW'(l.quo));
    return l.neg ? -m : m;
  endfunction

  // Pick the result and clamp it to the data range
  always_comb begin
    rv   = side.is_div ? lane_sgn(val_lane) : side.rv;
    rd   = side.is_div ? lane_sgn(der_lane) : side.rd;
    hi_v = rv > SAT_MAX;
    lo_v = rv < SAT_MIN;
    hi_d = rd > SAT_MAX;
    lo_d = rd < SAT_MIN;

    out_item_nxt.res_value = hi_v ? OUT_MAX : (lo_v ? OUT_MIN : DW'(rv));
    out_item_nxt.res_deriv = hi_d ? OUT_MAX : (lo_d ? OUT_MIN : DW'(rd));
    out_item_nxt.status    = (hi_v || lo_v || hi_d || lo_d) ? ST_SAT : ST_OK;
    if (side.bad) begin
      out_item_nxt.res_value = '0;
      out_item_nxt.res_deriv = '0;
      out_item_nxt.status    = ST_DIV;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == ST_DIV
    |-> out_item_r.res_value == '0 && out_item_r.res_deriv == '0)
    else $error("bad divisor item with nonzero result");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == ST_SAT
    |-> out_item_r.res_value == OUT_MAX || out_item_r.res_value == OUT_MIN ||
        out_item_r.res_deriv == OUT_MAX || out_item_r.res_deriv == OUT_MIN)
    else $error("saturation status without a clamped result");

  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_vld))
    else $error("result appeared without an item behind it");

endmodule

[dv/tb_dual_number_alu_core.sv]
// ----------------------------------------------------------------------------
// tb_dual_number_alu_core
// Self-checking bench for the dual number ALU. A directed table covers
// operand extremes, every operation, divisor sign cases and saturation;
// random items follow under several sender and receiver idling phases.
// Results are matched in order against a wide-integer predictor.
// ----------------------------------------------------------------------------
module tb_dual_number_alu_core;
  import dna_pkg::*;

  localparam int LAT       = 36;
  localparam int N_RANDOM  = 400;
  localparam int MAX_CYCLE = 400000;
  localparam int HOLD_LEN  = 120;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [159:0]  wide_t;

  typedef struct {
    op_t   op;
    word_t av, ad, bv, bd;
    logic  known;
    word_t rv, rd;
    status_t st;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  out_item_t   pending_q[$];
  out_item_t   typed_q[$];
  logic        typed_flag_q[$];
  int          n_errors = 0;
  int          n_results = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_off = 0;
  logic        hold_req = 1'b0;
  logic        hold_used = 1'b0;

  dual_number_alu_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Divide with truncation toward zero; d is positive
  function automatic wide_t div_trunc(wide_t n, wide_t d);
    wide_t q;
    q = (n < 0) ? -((-n) / d) : n / d;
    return q;
  endfunction

  // Floor shift of an exact product
  function automatic wide_t floor_scale(wide_t n);
    return n >>> FB;
  endfunction

  // Clamp to the data range; raise the saturation flag if clamped
  function automatic word_t clamp_word(wide_t x, ref logic sat);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (DW - 1)) - 1;
    lo = -(wide_t'(1) <<< (DW - 1));
    if (x > hi) begin
      sat = 1'b1;
      return word_t'(hi);
    end
    if (x < lo) begin
      sat = 1'b1;
      return word_t'(lo);
    end
    return word_t'(x);
  endfunction

  // Predict value, derivative and status of one dual number operation
  function automatic out_item_t dual_result(in_item_t it);
    out_item_t r;
    wide_t av, ad, bv, bd, xv, xd;
    logic sat;
    av = it.a_value; ad = it.a_deriv; bv = it.b_value; bd = it.b_deriv;
    sat = 1'b0;
    case (op_t'(it.req_type))
      OP_ADD: begin
        xv = av + bv; xd = ad + bd;
      end
      OP_SUB: begin
        xv = av - bv; xd = ad - bd;
      end
      OP_MUL: begin
        xv = floor_scale(av * bv);
        xd = floor_scale(av * bd + ad * bv);
      end
      default: begin
        if (bv <= 0) begin
          r.res_value = '0; r.res_deriv = '0; r.status = ST_DIV;
          return r;
        end
        xv = div_trunc(av <<< FB, bv);
        xd = div_trunc((ad * bv - av * bd) <<< FB, bv * bv);
      end
    endcase
    r.res_value = clamp_word(xv, sat);
    r.res_deriv = clamp_word(xd, sat);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Random operand, biased toward extremes and small magnitudes
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return word_t'(32'h7fff_ffff);
      1: return word_t'(32'h8000_0000);
      2: return word_t'($urandom_range(0, 8) - 4);
      3: return word_t'(signed'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      4: return word_t'(signed'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Sender: idle for a while, then present one item and wait for acceptance
  task automatic send_item(in_item_t it, logic known, out_item_t exp_r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(dual_result(it));
    typed_q.push_back(exp_r);
    typed_flag_q.push_back(known);
  endtask

  // Drop valid and hold until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_off  <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_item_t e, t;
    logic k;
    if (rst_n && out_valid && !out_stall) begin
      n_results <= n_results + 1;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        n_errors = n_errors + 1;
      end else begin
        e = pending_q.pop_front();
        t = typed_q.pop_front();
        k = typed_flag_q.pop_front();
        if (k && t != e) begin
          $display("%0t: table row disagrees with predictor: table %h predicted %h",
                   $time, t, e);
          n_errors = n_errors + 1;
        end
        if (out_item.res_value !== e.res_value) begin
          $display("%0t: res_value expected %h actual %h", $time, e.res_value,
                   out_item.res_value);
          n_errors = n_errors + 1;
        end
        if (out_item.res_deriv !== e.res_deriv) begin
          $display("%0t: res_deriv expected %h actual %h", $time, e.res_deriv,
                   out_item.res_deriv);
          n_errors = n_errors + 1;
        end
        if (out_item.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status,
                   out_item.status);
          n_errors = n_errors + 1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("dual_number_alu_core verification failed");
      $finish;
    end
  end

  localparam word_t ONE  = 32'sh0001_0000;
  localparam word_t TWO  = 32'sh0002_0000;
  localparam word_t WMAX = 32'sh7fff_ffff;
  localparam word_t WMIN = 32'sh8000_0000;

  // Directed table; known rows carry a hand-written result
  vec_t dir_tab[] = '{
    '{OP_ADD, ONE, TWO, ONE, ONE, 1'b1, TWO, 32'sh0003_0000, ST_OK},
    '{OP_SUB, ONE, TWO, TWO, ONE, 1'b1, -ONE, ONE, ST_OK},
    '{OP_ADD, WMAX, 0, ONE, 0, 1'b1, WMAX, 0, ST_SAT},
    '{OP_ADD, WMIN, WMIN, WMIN, 0, 1'b1, WMIN, WMIN, ST_SAT},
    '{OP_SUB, WMIN, WMAX, ONE, WMIN, 1'b1, WMIN, WMAX, ST_SAT},
    '{OP_SUB, 0, 0, WMIN, 0, 1'b1, WMAX, 0, ST_SAT},
    '{OP_MUL, TWO, ONE, TWO, ONE, 1'b1, 32'sh0004_0000, 32'sh0004_0000, ST_OK},
    '{OP_MUL, WMAX, WMAX, WMAX, WMAX, 1'b1, WMAX, WMAX, ST_SAT},
    '{OP_MUL, WMIN, WMIN, WMIN, WMAX, 1'b1, WMAX, 32'sh0000_8000, ST_SAT},
    '{OP_MUL, -1, 0, 1, 0, 1'b1, -1, 0, ST_OK},
    '{OP_MUL, WMIN, WMIN, WMIN, WMIN, 1'b0, 0, 0, ST_OK},
    '{OP_DIV, ONE, ONE, 0, ONE, 1'b1, 0, 0, ST_DIV},
    '{OP_DIV, WMAX, WMAX, -1, WMAX, 1'b1, 0, 0, ST_DIV},
    '{OP_DIV, ONE, WMIN, WMIN, 0, 1'b1, 0, 0, ST_DIV},
    '{OP_DIV, TWO, 0, TWO, 0, 1'b1, ONE, 0, ST_OK},
    '{OP_DIV, WMAX, WMAX, 1, WMIN, 1'b1, WMAX, WMAX, ST_SAT},
    '{OP_DIV, WMIN, WMIN, 1, WMAX, 1'b1, WMIN, WMAX, ST_SAT},
    '{OP_DIV, -ONE, ONE, 32'sh0003_0000, ONE, 1'b0, 0, 0, ST_OK},
    '{OP_DIV, WMIN, WMAX, WMAX, WMIN, 1'b0, 0, 0, ST_OK},
    '{OP_MUL, 32'sh5555_aaaa, 32'shaaaa_5555, 32'sh0000_ffff, 32'shffff_0000,
      1'b0, 0, 0, ST_OK}
  };

  initial begin
    in_item_t it;
    out_item_t r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    foreach (dir_tab[i]) begin
      it = '{dir_tab[i].op, dir_tab[i].av, dir_tab[i].ad, dir_tab[i].bv, dir_tab[i].bd};
      r = '{dir_tab[i].rv, dir_tab[i].rd, dir_tab[i].st};
      send_item(it, dir_tab[i].known, r);
    end

    // Random phases: none, sender idle, receiver stall, both, long hold-off
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        3: begin send_idle_pct = 15; stall_pct = 15; end
        default: begin send_idle_pct = 0; stall_pct = 0; hold_req = 1'b1; end
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        it.req_type = 2'($urandom_range(0, 3));
        it.a_value = rand_word();
        it.a_deriv = rand_word();
        it.b_value = rand_word();
        it.b_deriv = rand_word();
        send_item(it, 1'b0, r);
      end
      // After the sender idle phase, pause until everything has drained
      if (ph == 1) wait_drained();
    end

    stall_pct = 0;
    wait_drained();
    repeat (LAT + 4) @(posedge clk);
    $display("Covered %0d results: directed extremes, all four operations,",
             n_results);
    $display("bad divisors and saturation, under idle, stall and hold-off phases.");
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("dual_number_alu_core verification clean");
    end else begin
      $display("dual_number_alu_core verification failed");
    end
    $finish;
  end

endmodule

[dual_number_alu_core.f]
sv/dna_pkg.sv
sv/dna_front.sv
sv/dna_divider.sv
sv/dna_back.sv
sv/dual_number_alu_core.sv
dv/tb_dual_number_alu_core.sv
